// ===== hdl/cre_pkg.sv =====
// Shared types and constants for the CORDIC rotation engine.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package cre_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 5;

  // Request kinds on the input channel
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_ROTATE = 1'b1
  } action_t;

  // Payload carried by every pipeline stage. A load request rides in the
  // same slot: its angle value travels in z and its entry number in index.
  typedef struct packed {
    logic                      rotate;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  x;
    logic signed [DATA_W-1:0]  y;
    logic signed [DATA_W-1:0]  z;
  } stage_t;

endpackage

// ===== hdl/cre_if.sv =====
// Valid/ready channel interfaces for the CORDIC rotation engine.
// Depends on cre_pkg for the data widths and the request kind.
`timescale 1ns / 1ps

interface cre_in_if import cre_pkg::*; ();
  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic [INDEX_W-1:0]       table_index;
  logic signed [DATA_W-1:0] table_value;
  logic signed [DATA_W-1:0] x_in;
  logic signed [DATA_W-1:0] y_in;
  logic signed [DATA_W-1:0] z_in;

  modport source (output valid, action, table_index, table_value, x_in, y_in, z_in,
                  input ready);
  modport sink   (input valid, action, table_index, table_value, x_in, y_in, z_in,
                  output ready);
endinterface

interface cre_out_if import cre_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_out;
  logic signed [DATA_W-1:0] y_out;

  modport source (output valid, x_out, y_out, input ready);
  modport sink   (input valid, x_out, y_out, output ready);
endinterface

// ===== hdl/cordic_rotation_engine_core.sv =====
// Integer CORDIC rotation engine: a pipeline of cre_stage instances.
// Depends on cre_pkg, cre_if (cre_in_if, cre_out_if) and cre_stage.
`timescale 1ns / 1ps

// A rotate request travels through every stage of the pipeline, one
// micro-rotation per register stage, and its x and y then wait in the last
// stage, which is the output register. One request is taken per cycle while
// the output side keeps up; when a result waits unaccepted the whole pipeline
// freezes, and in_ch.ready drops in the same cycle. A load request takes one
// pipeline slot, writes its angle as it passes the stage that owns that
// table entry, and yields no result, so rotates behind it see the new angle
// and rotates ahead of it keep the old one. Indexes of ITERATIONS or more
// match no stage and are dropped.
module cordic_rotation_engine_core import cre_pkg::*; #(
  parameter int unsigned ITERATIONS = 28
) (
  input logic        clk,
  input logic        rst_n,
  cre_in_if.sink     in_ch,
  cre_out_if.source  out_ch
);

  stage_t pipe       [ITERATIONS+1];
  logic   pipe_valid [ITERATIONS+1];
  logic   en;

  // Freeze everything while a finished result is still waiting
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Pack the incoming request into the stage format
  assign pipe_valid[0]  = in_ch.valid;
  assign pipe[0].rotate = (in_ch.action == ACT_ROTATE);
  assign pipe[0].index  = in_ch.table_index;
  assign pipe[0].x      = in_ch.x_in;
  assign pipe[0].y      = in_ch.y_in;
  assign pipe[0].z      = (in_ch.action == ACT_ROTATE) ? in_ch.z_in : in_ch.table_value;

  // One micro-rotation per stage
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
    cre_stage #(
      .SHIFT (k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .d_valid (pipe_valid[k]),
      .d       (pipe[k]),
      .q_valid (pipe_valid[k+1]),
      .q       (pipe[k+1])
    );
  end

  // Present rotate results only; loads drain silently
  assign out_ch.valid = pipe_valid[ITERATIONS] && pipe[ITERATIONS].rotate;
  assign out_ch.x_out = pipe[ITERATIONS].x;
  assign out_ch.y_out = pipe[ITERATIONS].y;

  // A waiting result must block new requests
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // A frozen pipeline keeps its first stage occupancy
  a_stall_holds_first: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> pipe_valid[1] == $past(pipe_valid[1]))
    else $error("first stage changed during stall");

  // An accepted rotate lands in the first stage as a rotate
  a_rotate_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.action == ACT_ROTATE
      |=> pipe_valid[1] && pipe[1].rotate)
    else $error("accepted rotate request lost at first stage");

endmodule

// ===== hdl/cre_stage.sv =====
// One CORDIC micro-rotation stage with its own angle table entry.
// Depends on cre_pkg for stage_t and the data widths.
`timescale 1ns / 1ps

module cre_stage import cre_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   d_valid,
  input  stage_t d,
  output logic   q_valid,
  output stage_t q
);

  logic signed [DATA_W-1:0] angle_r;
  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic                     z_neg;
  stage_t                   q_nxt;
  logic                     q_valid_r;
  stage_t                   q_r;

  // Store the angle when a load request for this entry passes through
  always_ff @(posedge clk) begin
    if (en && d_valid && !d.rotate && (d.index == INDEX_W'(SHIFT))) begin
      angle_r <= d.z;
    end
  end

  // Rotate toward zero residual angle; loads pass through untouched
  always_comb begin
    xs    = $signed(d.x) >>> SHIFT;
    ys    = $signed(d.y) >>> SHIFT;
    z_neg = d.z[DATA_W-1];
    q_nxt = d;
    if (d.rotate) begin
      if (z_neg) begin
        q_nxt.x = d.x + ys;
        q_nxt.y = d.y - xs;
        q_nxt.z = d.z + angle_r;
      end else begin
        q_nxt.x = d.x - ys;
        q_nxt.y = d.y + xs;
        q_nxt.z = d.z - angle_r;
      end
    end
  end

  // Advance the valid bit; hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (en) begin
      q_valid_r <= d_valid;
    end
  end

  // Advance the payload; hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_valid = q_valid_r;
  assign q       = q_r;

endmodule
